// ===== sv/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// Static linked list package
// Shared constants, operation and status codes, sequencer states and the
// write-enable group that the sequencer hands to the node store.
// ----------------------------------------------------------------------------
package sll_pkg;

   localparam int NODE_COUNT_DEF  = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND  = 3'd0,
      FUNC_INSERT  = 3'd1,
      FUNC_DELETE  = 3'd2,
      FUNC_SEARCH  = 3'd3,
      FUNC_READ    = 3'd4,
      FUNC_REPLACE = 3'd5,
      FUNC_CLEAR   = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_BAD_POS = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_WALK,
      ST_AP_LINK,
      ST_AP_END,
      ST_AP_TAIL,
      ST_INS_ALLOC,
      ST_INS_FREE,
      ST_INS_NEXT,
      ST_INS_PREV,
      ST_DEL_NEXT,
      ST_DEL_CUR,
      ST_DEL_UNLINK,
      ST_DEL_FREE,
      ST_DEL_PUSH,
      ST_SR_FIRST,
      ST_SR_SCAN,
      ST_RD_VALUE,
      ST_CLR_TAIL,
      ST_CLR_MOVE,
      ST_DONE
   } state_type;

   // Write controls for the node store.
   typedef struct packed {
      logic link_wr;     // write one next pointer
      logic value_wr;    // write one element
      logic clear_list;  // move the whole list head onto the free list head
   } sll_wen_type;

endpackage

// ===== sv/static_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// Static linked list engine
// Cursor-based linked list with a free list in a fixed node store.
// ----------------------------------------------------------------------------
// One item is worked at a time and req_stall stays high until its result has
// been loaded into the output register; the next item may be taken while that
// result still waits. Insert, delete, read and replace walk the list one node
// per cycle through the node store's single read port, and a walk that runs
// past the end stops there. Search scans the list until the first match or
// its end. After reset a clearing pass builds the free chain, and no item is
// taken until it ends.
// ----------------------------------------------------------------------------
module static_linked_list_engine import sll_pkg::*; #(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [POS_W-1:0]    req_position,
   input  logic [DATA_W-1:0]   req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [POS_W-1:0]    rsp_found_position,
   output logic [DATA_W-1:0]   rsp_value_out,
   output logic                rsp_is_empty,
   output logic                rsp_is_full
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int NODE_W = $clog2(NODE_COUNT + 1);
   localparam int CNT_W  = (NODE_W > POS_W) ? NODE_W : POS_W;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   func_type               func_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [VALUE_WIDTH-1:0] val_ff;

   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [IDX_W-1:0]       prev_ff, prev_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   status_type             status_ff, status_in;
   logic [POS_W-1:0]       found_ff, found_in;
   logic [VALUE_WIDTH-1:0] vout_ff, vout_in;

   status_type             rsp_status_ff;
   logic [POS_W-1:0]       rsp_found_ff;
   logic [DATA_W-1:0]      rsp_value_ff;
   logic                   rsp_empty_ff;
   logic                   rsp_full_ff;
   logic                   rsp_load;

   logic [VALUE_WIDTH+DATA_W-1:0] val_ext;
   logic [VALUE_WIDTH+DATA_W-1:0] vout_ext;

   logic                   accept;

   sll_wen_type            wen;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       lk_addr;
   logic [IDX_W-1:0]       lk_data;
   logic [IDX_W-1:0]       nxt;
   logic [VALUE_WIDTH-1:0] rd_value;
   logic [IDX_W-1:0]       head;
   logic [IDX_W-1:0]       free;
   logic                   busy;

   sll_node_store #(
      .NODE_COUNT  (NODE_COUNT),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wen      (wen),
      .rd_addr  (rd_addr),
      .lk_addr  (lk_addr),
      .lk_data  (lk_data),
      .val_addr (cur_in),
      .val_data (val_ff),
      .nxt      (nxt),
      .rd_value (rd_value),
      .head     (head),
      .free     (free),
      .busy     (busy)
   );

   assign req_stall = (state_ff != ST_IDLE) || busy;
   assign accept    = req_valid && !req_stall;

   // Widen then cut, so any element width fits the 32-bit ports.
   assign val_ext  = {{VALUE_WIDTH{1'b0}}, req_value};
   assign vout_ext = {{DATA_W{1'b0}}, vout_ff};

   always_comb begin
      state_in     = state_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      vout_in      = vout_ff;
      wen          = '0;
      rd_addr      = '0;
      lk_addr      = '0;
      lk_data      = '0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_START;
            end
         end

         ST_START: begin
            status_in = STATUS_OK;
            found_in  = '0;
            vout_in   = '0;
            state_in  = ST_DONE;
            case (func_ff)
               FUNC_APPEND: begin
                  if (free == '0) begin
                     status_in = STATUS_FULL;
                  end else begin
                     rd_addr  = free;
                     cur_in   = free;
                     state_in = ST_AP_LINK;
                  end
               end
               FUNC_INSERT: begin
                  if (pos_ff == '0) begin
                     status_in = STATUS_BAD_POS;
                  end else if (free == '0) begin
                     status_in = STATUS_FULL;
                  end else if (pos_ff == POS_W'(1)) begin
                     prev_in  = '0;
                     state_in = ST_INS_ALLOC;
                  end else begin
                     cnt_in   = CNT_W'(pos_ff) - CNT_W'(1);
                     state_in = ST_WALK;
                  end
               end
               FUNC_DELETE: begin
                  if (pos_ff == '0) begin
                     status_in = STATUS_BAD_POS;
                  end else if (head == '0) begin
                     status_in = STATUS_EMPTY;
                  end else if (pos_ff == POS_W'(1)) begin
                     prev_in  = '0;
                     state_in = ST_DEL_NEXT;
                  end else begin
                     cnt_in   = CNT_W'(pos_ff) - CNT_W'(1);
                     state_in = ST_WALK;
                  end
               end
               FUNC_SEARCH: begin
                  cnt_in   = CNT_W'(1);
                  state_in = ST_SR_FIRST;
               end
               FUNC_READ, FUNC_REPLACE: begin
                  if (pos_ff == '0) begin
                     status_in = STATUS_BAD_POS;
                  end else begin
                     cnt_in   = CNT_W'(pos_ff);
                     state_in = ST_WALK;
                  end
               end
               FUNC_CLEAR: begin
                  if (tail_ff != '0) begin
                     state_in = ST_CLR_TAIL;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // One node per cycle: the pointer just read addresses the next read.
         ST_WALK: begin
            if (nxt == '0) begin
               status_in = STATUS_BAD_POS;
               state_in  = ST_DONE;
            end else begin
               rd_addr = nxt;
               if (cnt_ff == CNT_W'(1)) begin
                  prev_in = nxt;
                  case (func_ff)
                     FUNC_INSERT: state_in = ST_INS_ALLOC;
                     FUNC_DELETE: state_in = ST_DEL_CUR;
                     FUNC_READ:   state_in = ST_RD_VALUE;
                     FUNC_REPLACE: begin
                        cur_in       = nxt;
                        wen.value_wr = 1'b1;
                        state_in     = ST_DONE;
                     end
                     default:     state_in = ST_DONE;
                  endcase
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end

         ST_AP_LINK: begin
            wen.link_wr  = 1'b1;
            lk_addr      = IDX_W'(1);
            lk_data      = nxt;
            wen.value_wr = 1'b1;
            state_in     = ST_AP_END;
         end

         ST_AP_END: begin
            wen.link_wr = 1'b1;
            lk_addr     = cur_ff;
            lk_data     = '0;
            state_in    = ST_AP_TAIL;
         end

         ST_AP_TAIL: begin
            wen.link_wr = 1'b1;
            lk_addr     = tail_ff;
            lk_data     = cur_ff;
            tail_in     = cur_ff;
            state_in    = ST_DONE;
         end

         ST_INS_ALLOC: begin
            rd_addr  = free;
            cur_in   = free;
            state_in = ST_INS_FREE;
         end

         ST_INS_FREE: begin
            wen.link_wr  = 1'b1;
            lk_addr      = IDX_W'(1);
            lk_data      = nxt;
            wen.value_wr = 1'b1;
            rd_addr      = prev_ff;
            state_in     = ST_INS_NEXT;
         end

         ST_INS_NEXT: begin
            wen.link_wr = 1'b1;
            lk_addr     = cur_ff;
            lk_data     = nxt;
            if (nxt == '0) begin
               tail_in = cur_ff;
            end
            state_in = ST_INS_PREV;
         end

         ST_INS_PREV: begin
            wen.link_wr = 1'b1;
            lk_addr     = prev_ff;
            lk_data     = cur_ff;
            state_in    = ST_DONE;
         end

         ST_DEL_NEXT: begin
            rd_addr  = prev_ff;
            state_in = ST_DEL_CUR;
         end

         ST_DEL_CUR: begin
            if (nxt == '0) begin
               status_in = STATUS_BAD_POS;
               state_in  = ST_DONE;
            end else begin
               cur_in   = nxt;
               rd_addr  = nxt;
               state_in = ST_DEL_UNLINK;
            end
         end

         ST_DEL_UNLINK: begin
            vout_in     = rd_value;
            wen.link_wr = 1'b1;
            lk_addr     = prev_ff;
            lk_data     = nxt;
            if (tail_ff == cur_ff) begin
               tail_in = prev_ff;
            end
            state_in = ST_DEL_FREE;
         end

         ST_DEL_FREE: begin
            wen.link_wr = 1'b1;
            lk_addr     = cur_ff;
            lk_data     = free;
            state_in    = ST_DEL_PUSH;
         end

         ST_DEL_PUSH: begin
            wen.link_wr = 1'b1;
            lk_addr     = IDX_W'(1);
            lk_data     = cur_ff;
            state_in    = ST_DONE;
         end

         ST_SR_FIRST: begin
            if (nxt == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_addr  = nxt;
               state_in = ST_SR_SCAN;
            end
         end

         // Each read returns both the element and the link of one node.
         ST_SR_SCAN: begin
            if (rd_value == val_ff) begin
               found_in = cnt_ff[POS_W-1:0];
               state_in = ST_DONE;
            end else if (nxt == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_addr = nxt;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end

         ST_RD_VALUE: begin
            vout_in  = rd_value;
            state_in = ST_DONE;
         end

         ST_CLR_TAIL: begin
            wen.link_wr = 1'b1;
            lk_addr     = tail_ff;
            lk_data     = free;
            state_in    = ST_CLR_MOVE;
         end

         ST_CLR_MOVE: begin
            wen.clear_list = 1'b1;
            tail_in        = '0;
            state_in       = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_func);
         pos_ff  <= req_position;
         val_ff  <= val_ext[VALUE_WIDTH-1:0];
      end
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      vout_ff   <= vout_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_value_ff  <= vout_ext[DATA_W-1:0];
         rsp_empty_ff  <= (head == '0);
         rsp_full_ff   <= (free == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_is_full        = rsp_full_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_START))
      else $error("accepted item did not start the sequencer");

   a_tail_matches_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((tail_ff == '0) == (head == '0)))
      else $error("tail and list head disagree on emptiness");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL)) |-> rsp_full_ff)
      else $error("list full reported while free nodes remain");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_EMPTY)) |-> rsp_empty_ff)
      else $error("list empty reported while elements remain");

   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cnt_ff != '0))
      else $error("list walk running with a zero step count");

endmodule

// ===== sv/sll_node_store.sv =====
// ----------------------------------------------------------------------------
// Static linked list node store
// Next-pointer and element memories with one registered read port. The next
// pointers of the list head (node 0) and free head (node 1) live in registers.
// After reset the store sweeps the free chain into the next-pointer memory.
// ----------------------------------------------------------------------------
module sll_node_store import sll_pkg::*; #(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   localparam int IDX_W      = $clog2(NODE_COUNT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sll_wen_type            wen,
   input  logic [IDX_W-1:0]       rd_addr,
   input  logic [IDX_W-1:0]       lk_addr,
   input  logic [IDX_W-1:0]       lk_data,
   input  logic [IDX_W-1:0]       val_addr,
   input  logic [VALUE_WIDTH-1:0] val_data,
   output logic [IDX_W-1:0]       nxt,
   output logic [VALUE_WIDTH-1:0] rd_value,
   output logic [IDX_W-1:0]       head,
   output logic [IDX_W-1:0]       free,
   output logic                   busy
);

   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NODE_COUNT - 1);
   localparam logic [IDX_W-1:0] FIRST_FREE = IDX_W'(2);
   localparam logic [IDX_W-1:0] HEAD_IDX   = IDX_W'(0);
   localparam logic [IDX_W-1:0] FREE_IDX   = IDX_W'(1);

   logic [IDX_W-1:0]       next_mem [NODE_COUNT];
   logic [VALUE_WIDTH-1:0] value_mem [NODE_COUNT];

   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       free_ff, free_in;
   logic                   busy_ff, busy_in;
   logic [IDX_W-1:0]       init_idx_ff, init_idx_in;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [IDX_W-1:0]       next_q_ff;
   logic [VALUE_WIDTH-1:0] value_q_ff;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [IDX_W-1:0]       mem_wd;

   always_comb begin
      head_in     = head_ff;
      free_in     = free_ff;
      busy_in     = busy_ff;
      init_idx_in = init_idx_ff;
      mem_we      = 1'b0;
      mem_wa      = lk_addr;
      mem_wd      = lk_data;
      if (busy_ff) begin
         // Clearing pass: chain every node from 2 up, the last one ends.
         mem_we = 1'b1;
         mem_wa = init_idx_ff;
         if (init_idx_ff == LAST_IDX) begin
            mem_wd  = '0;
            busy_in = 1'b0;
         end else begin
            mem_wd      = init_idx_ff + IDX_W'(1);
            init_idx_in = init_idx_ff + IDX_W'(1);
         end
      end else if (wen.link_wr) begin
         if (lk_addr == HEAD_IDX) begin
            head_in = lk_data;
         end else if (lk_addr == FREE_IDX) begin
            free_in = lk_data;
         end else begin
            mem_we = 1'b1;
         end
      end
      if (wen.clear_list) begin
         free_in = head_ff;
         head_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         free_ff     <= FIRST_FREE;
         busy_ff     <= 1'b1;
         init_idx_ff <= FIRST_FREE;
      end else begin
         head_ff     <= head_in;
         free_ff     <= free_in;
         busy_ff     <= busy_in;
         init_idx_ff <= init_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         next_mem[mem_wa] <= mem_wd;
      end
      if (wen.value_wr) begin
         value_mem[val_addr] <= val_data;
      end
      next_q_ff  <= next_mem[rd_addr];
      value_q_ff <= value_mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // The two head nodes answer from their registers.
   assign nxt = (rd_idx_ff == HEAD_IDX) ? head_ff :
                (rd_idx_ff == FREE_IDX) ? free_ff : next_q_ff;

   assign rd_value = value_q_ff;
   assign head     = head_ff;
   assign free     = free_ff;
   assign busy     = busy_ff;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Static linked list engine testbench
// Feeds list operations through the request channel and checks every
// response against a behavioral copy of the list kept in the bench. A short
// directed sequence covers the corner cases, and random grow, shrink, mixed
// and clear episodes follow. Both channels idle at random, and the response
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import sll_pkg::*;

   localparam int CAPACITY     = NODE_COUNT_DEF - 2;
   localparam int TOTAL_ITEMS  = 2025;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = NODE_COUNT_DEF + 16;
   localparam int PRESSURE_AT  = 400;
   localparam int PRESSURE_LEN = 500;
   localparam int QUIET_FROM   = 1200;
   localparam int QUIET_TO     = 1500;

   // Code 7 is not an operation; the block must leave the list alone.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
   } list_req;

   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  found;
      logic [DATA_W-1:0] value_out;
      logic              is_empty;
      logic              is_full;
   } list_result;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [DATA_W-1:0]   req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [POS_W-1:0]    rsp_found_position;
   logic [DATA_W-1:0]   rsp_value_out;
   logic                rsp_is_empty;
   logic                rsp_is_full;

   static_linked_list_engine u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_value_out      (rsp_value_out),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full)
   );

   list_req    pending_ops[$];
   list_result expected_results[$];

   // Bench copy of the node store.
   logic [DATA_W-1:0] node_val [NODE_COUNT_DEF];
   logic [POS_W-1:0]  node_link [NODE_COUNT_DEF];
   logic [POS_W-1:0]  tail_idx;

   logic [DATA_W-1:0] value_pool [16];
   int  shadow_len = 0;
   int  ops_accepted = 0;
   int  results_checked = 0;
   int  mismatch_cnt = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   int  full_seen = 0;
   int  cycle_cnt = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   int  run_left = 0;
   bit  run_stall = 1'b0;
   bit  pressure_done = 1'b0;
   logic req_fire = 1'b0;

   wire quiet = (ops_accepted >= QUIET_FROM) && (ops_accepted < QUIET_TO);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int draw_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 40) return value_pool[$urandom_range(0, 15)];
      return $urandom;
   endfunction

   // Mostly a position inside 1..hi, otherwise anything the field holds.
   function automatic logic [POS_W-1:0] pick_pos(int hi);
      if (hi >= 1 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(1, hi));
      return POS_W'($urandom_range(0, 63));
   endfunction

   // Queues one item and tracks the list length it will leave behind.
   function automatic void push_op(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                   logic [DATA_W-1:0] v);
      list_req r;
      int      pos;
      r.func = f;
      r.position = p;
      r.value = v;
      pending_ops.push_back(r);
      pos = int'(p);
      case (f)
         FUNC_APPEND: if (shadow_len < CAPACITY) shadow_len++;
         FUNC_INSERT:
            if (pos != 0 && shadow_len < CAPACITY && pos <= shadow_len + 1) shadow_len++;
         FUNC_DELETE: if (pos != 0 && shadow_len > 0 && pos <= shadow_len) shadow_len--;
         FUNC_CLEAR: shadow_len = 0;
         default: ;
      endcase
   endfunction

   // Node at a 1-based position, 0 when the list is shorter.
   function automatic logic [POS_W-1:0] node_at(logic [POS_W-1:0] p);
      logic [POS_W-1:0] cur;
      int               i;
      cur = '0;
      for (i = 0; i < int'(p); i++) begin
         cur = node_link[cur];
         if (cur == 0) return '0;
      end
      return cur;
   endfunction

   function automatic logic [POS_W-1:0] take_free();
      logic [POS_W-1:0] n;
      n = node_link[1];
      node_link[1] = node_link[n];
      return n;
   endfunction

   // Applies one operation to the bench list and returns its response.
   function automatic list_result list_apply(list_req r);
      list_result       res;
      logic [POS_W-1:0] n, prev, cur;
      int               i;
      bit               done;
      res = '0;
      res.status = STATUS_OK;
      prev = '0;
      case (r.func)
         FUNC_APPEND: begin
            if (node_link[1] == 0) res.status = STATUS_FULL;
            else begin
               n = take_free();
               node_val[n] = r.value;
               node_link[n] = '0;
               node_link[tail_idx] = n;
               tail_idx = n;
            end
         end
         FUNC_INSERT: begin
            if (r.position == 0) res.status = STATUS_BAD_POS;
            else if (node_link[1] == 0) res.status = STATUS_FULL;
            else begin
               if (r.position != 1) prev = node_at(r.position - 1'b1);
               if (r.position != 1 && prev == 0) res.status = STATUS_BAD_POS;
               else begin
                  n = take_free();
                  node_val[n] = r.value;
                  node_link[n] = node_link[prev];
                  node_link[prev] = n;
                  if (node_link[n] == 0) tail_idx = n;
               end
            end
         end
         FUNC_DELETE: begin
            if (r.position == 0) res.status = STATUS_BAD_POS;
            else if (node_link[0] == 0) res.status = STATUS_EMPTY;
            else begin
               if (r.position != 1) prev = node_at(r.position - 1'b1);
               cur = node_link[prev];
               if ((r.position != 1 && prev == 0) || cur == 0) res.status = STATUS_BAD_POS;
               else begin
                  if (tail_idx == cur) tail_idx = prev;
                  node_link[prev] = node_link[cur];
                  node_link[cur] = node_link[1];
                  node_link[1] = cur;
                  res.value_out = node_val[cur];
               end
            end
         end
         FUNC_SEARCH: begin
            cur = '0;
            done = 1'b0;
            for (i = 1; i <= NODE_COUNT_DEF && !done; i++) begin
               cur = node_link[cur];
               if (cur == 0) done = 1'b1;
               else if (node_val[cur] == r.value) begin
                  res.found = POS_W'(i);
                  done = 1'b1;
               end
            end
         end
         FUNC_READ, FUNC_REPLACE: begin
            cur = (r.position == 0) ? '0 : node_at(r.position);
            if (cur == 0) res.status = STATUS_BAD_POS;
            else if (r.func == FUNC_READ) res.value_out = node_val[cur];
            else node_val[cur] = r.value;
         end
         FUNC_CLEAR: begin
            if (tail_idx != 0) begin
               node_link[tail_idx] = node_link[1];
               node_link[1] = node_link[0];
               node_link[0] = '0;
               tail_idx = '0;
            end
         end
         default: ;
      endcase
      res.is_empty = (node_link[0] == 0);
      res.is_full = (node_link[1] == 0);
      return res;
   endfunction

   // Stimulus and end of run.
   initial begin
      int i, kind, steps, extra;
      for (i = 0; i < NODE_COUNT_DEF; i++) begin
         node_val[i] = '0;
         node_link[i] = (i == 0 || i == NODE_COUNT_DEF - 1) ? '0 : POS_W'(i + 1);
      end
      tail_idx = '0;
      for (i = 0; i < 16; i++) value_pool[i] = $urandom;
      value_pool[0] = '0;
      value_pool[1] = '1;

      // Corner cases on an empty and then a short list.
      push_op(FUNC_SEARCH, 6'd0, 32'h0000_0000);
      push_op(FUNC_DELETE, 6'd1, 32'h0000_0000);
      push_op(FUNC_DELETE, 6'd0, 32'h0000_0000);
      push_op(FUNC_CLEAR, 6'd0, 32'h0000_0000);
      push_op(FUNC_READ, 6'd1, 32'h0000_0000);
      push_op(FUNC_REPLACE, 6'd1, 32'h1111_1111);
      push_op(FUNC_INSERT, 6'd2, 32'h2222_2222);
      push_op(FUNC_INSERT, 6'd0, 32'h3333_3333);
      push_op(FUNC_APPEND, 6'd63, 32'hFFFF_FFFF);
      push_op(FUNC_APPEND, 6'd0, 32'h0000_0000);
      push_op(FUNC_INSERT, 6'd1, 32'hA5A5_5A5A);
      push_op(FUNC_INSERT, 6'd4, 32'h1234_5678);
      push_op(FUNC_READ, 6'd0, 32'h0000_0000);
      push_op(FUNC_REPLACE, 6'd0, 32'h4444_4444);
      push_op(FUNC_READ, 6'd63, 32'h0000_0000);
      push_op(FUNC_DELETE, 6'd63, 32'h0000_0000);
      push_op(FUNC_SEARCH, 6'd0, 32'h0000_0000);
      push_op(FUNC_SEARCH, 6'd63, 32'hFFFF_FFFF);
      push_op(FUNC_SEARCH, 6'd5, 32'hDEAD_BEEF);
      push_op(FUNC_REPLACE, 6'd2, 32'h8000_0001);
      push_op(FUNC_READ, 6'd2, 32'h0000_0000);
      push_op(FUNC_UNUSED, 6'd63, 32'hFFFF_FFFF);
      push_op(FUNC_DELETE, 6'd4, 32'h0000_0000);
      push_op(FUNC_DELETE, 6'd1, 32'h0000_0000);
      push_op(FUNC_CLEAR, 6'd0, 32'h0000_0000);

      // Random episodes: fill to capacity, drain to empty, a loose mix or a clear.
      while (pending_ops.size() < TOTAL_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            while (shadow_len < CAPACITY) begin
               steps = $urandom_range(0, 99);
               if (steps < 8) push_op(FUNC_SEARCH, pick_pos(63), pick_value());
               else if (steps < 15) push_op(FUNC_READ, pick_pos(shadow_len), '0);
               else if (steps < 55) push_op(FUNC_APPEND, pick_pos(63), pick_value());
               else push_op(FUNC_INSERT, POS_W'($urandom_range(1, shadow_len + 1)),
                            pick_value());
            end
            extra = $urandom_range(1, 3);
            repeat (extra) push_op($urandom_range(0, 1) ? FUNC_APPEND : FUNC_INSERT,
                                   pick_pos(63), pick_value());
         end else if (kind < 50) begin
            while (shadow_len > 0) begin
               if ($urandom_range(0, 99) < 85)
                  push_op(FUNC_DELETE, POS_W'($urandom_range(1, shadow_len)), pick_value());
               else
                  push_op($urandom_range(0, 1) ? FUNC_SEARCH : FUNC_READ,
                          pick_pos(shadow_len), pick_value());
            end
            push_op(FUNC_DELETE, pick_pos(63), pick_value());
         end else if (kind < 90) begin
            steps = $urandom_range(20, 60);
            repeat (steps) begin
               kind = $urandom_range(0, 99);
               if (kind < 15) push_op(FUNC_APPEND, pick_pos(63), pick_value());
               else if (kind < 30) push_op(FUNC_INSERT, pick_pos(shadow_len + 1), pick_value());
               else if (kind < 45) push_op(FUNC_DELETE, pick_pos(shadow_len), pick_value());
               else if (kind < 65) push_op(FUNC_SEARCH, pick_pos(63), pick_value());
               else if (kind < 80) push_op(FUNC_READ, pick_pos(shadow_len), pick_value());
               else if (kind < 95) push_op(FUNC_REPLACE, pick_pos(shadow_len), pick_value());
               else if (kind < 98) push_op(FUNC_CLEAR, pick_pos(63), pick_value());
               else push_op(FUNC_UNUSED, pick_pos(63), pick_value());
            end
         end else begin
            push_op(FUNC_CLEAR, pick_pos(63), pick_value());
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (pending_ops.size() != 0 || req_valid);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items checked; status ok %0d, full %0d, bad position %0d, empty %0d",
               results_checked, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      $display("list reported full on %0d responses, %0d mismatches", full_seen,
               mismatch_cnt);
      if (mismatch_cnt == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Request driver: a new item only once the previous one has been taken.
   always @(negedge clock) begin
      list_req nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0 && !quiet) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            nxt = pending_ops.pop_front();
            req_func <= nxt.func;
            req_position <= nxt.position;
            req_value <= nxt.value;
            req_valid <= 1'b1;
            gap_left = draw_idle();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure, with one long hold-off to fill the block.
   always @(negedge clock) begin
      if (!pressure_done && ops_accepted >= PRESSURE_AT) begin
         hold_left = PRESSURE_LEN;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_stall = ($urandom_range(0, 99) < 35);
            run_left = run_stall ? 1 + draw_idle() : $urandom_range(1, 20);
         end
         run_left--;
         rsp_stall <= run_stall;
      end
   end

   // Both handshakes are sampled here, at the rising edge.
   always @(posedge clock) begin
      list_req    taken;
      list_result got, want;
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         taken.func = req_func;
         taken.position = req_position;
         taken.value = req_value;
         expected_results.push_back(list_apply(taken));
         ops_accepted++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = status_type'(rsp_status);
         got.found = rsp_found_position;
         got.value_out = rsp_value_out;
         got.is_empty = rsp_is_empty;
         got.is_full = rsp_is_full;
         if (expected_results.size() == 0) begin
            if (mismatch_cnt < 10)
               $display("unexpected response at cycle %0d: status %0d value %h",
                        cycle_cnt, got.status, got.value_out);
            mismatch_cnt++;
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               if (mismatch_cnt < 10)
                  $display("mismatch on response %0d (expected/actual): status %0d/%0d %s %0d/%0d %s %h/%h %s %b/%b %s %b/%b",
                           results_checked, want.status, got.status,
                           "found", want.found, got.found, "value", want.value_out,
                           got.value_out, "empty", want.is_empty, got.is_empty,
                           "full", want.is_full, got.is_full);
               mismatch_cnt++;
            end
            status_seen[want.status]++;
            if (want.is_full) full_seen++;
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding", cycle_cnt,
                  expected_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
